### rtl/fst_pkg.sv
// Package for the first-free slot table: sizes, operation codes and the
// payload and control structs shared by the RTL modules.
// Depends on nothing.
package fst_pkg;

  localparam int unsigned MaxSlots    = 64;
  localparam int unsigned SlotW       = $clog2(MaxSlots);
  localparam int unsigned MarkW       = $clog2(MaxSlots + 1);
  localparam int unsigned CapW        = 7;
  localparam int unsigned CmpW        = (CapW > MarkW) ? CapW : MarkW;
  localparam int unsigned IndexW      = 6;
  localparam int unsigned ResultSlotW = 6;
  localparam int unsigned HandleW     = 32;

  localparam logic [CapW-1:0] CapReset = CapW'(64);

  typedef enum logic [1:0] {
    KindAdd    = 2'd0,
    KindRemove = 2'd1,
    KindRead   = 2'd2,
    KindFlush  = 2'd3
  } kind_e;

  localparam logic StatusOk   = 1'b0;
  localparam logic StatusFail = 1'b1;

  typedef struct packed {
    kind_e              kind;
    logic [IndexW-1:0]  slot_index;
    logic [HandleW-1:0] handle;
  } in_t;

  typedef struct packed {
    logic                   status;
    logic [ResultSlotW-1:0] result_slot;
    logic [HandleW-1:0]     read_handle;
  } out_t;

  typedef struct packed {
    logic               en;
    logic [SlotW-1:0]   addr;
    logic [HandleW-1:0] data;
  } wr_t;

endpackage

### rtl/fst_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; the contents have no reset.
module fst_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/fst_alloc.sv
// Slot allocator: occupancy bits, high-water mark, first-free search and the
// decision for one operation. Depends on fst_pkg.
module fst_alloc (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fire_i,
  input  fst_pkg::in_t           item_i,
  input  logic [fst_pkg::HandleW-1:0] rdata_i,
  input  logic [fst_pkg::CapW-1:0]    cap_i,
  output fst_pkg::out_t          res_o,
  output fst_pkg::wr_t           wr_o
);
  import fst_pkg::*;

  logic [MaxSlots-1:0] occ_q, occ_d;
  logic [MarkW-1:0]    mark_q, mark_d;

  logic [CmpW-1:0]     mark_ext, eff_cap, idx_ext, slot_c;
  logic [MaxSlots-1:0] free_vec;
  logic                found, hit_occ, idx_ok, status_c, wr_en_c;
  logic [SlotW-1:0]    free_idx, wr_addr_c;
  logic [HandleW-1:0]  rd_c;

  always_comb begin
    mark_ext = CmpW'(mark_q);
    idx_ext  = CmpW'(item_i.slot_index);
    eff_cap  = (CmpW'(cap_i) < CmpW'(MaxSlots)) ? CmpW'(cap_i) : CmpW'(MaxSlots);
    // A slot index below the mark is always inside the table.
    idx_ok   = idx_ext < mark_ext;
    found    = 1'b0;
    free_idx = '0;
    hit_occ  = 1'b0;
    for (int i = 0; i < MaxSlots; i++) begin
      free_vec[i] = !occ_q[i] && (CmpW'(i) < mark_ext);
      if (CmpW'(i) == idx_ext) begin
        hit_occ = occ_q[i];
      end
    end
    // Scan from the top so the lowest free slot wins.
    for (int i = MaxSlots - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        found    = 1'b1;
        free_idx = SlotW'(i);
      end
    end
  end

  always_comb begin
    occ_d     = occ_q;
    mark_d    = mark_q;
    status_c  = StatusFail;
    slot_c    = '0;
    rd_c      = '0;
    wr_en_c   = 1'b0;
    wr_addr_c = '0;
    case (item_i.kind)
      KindAdd: begin
        if (found) begin
          status_c        = StatusOk;
          slot_c          = CmpW'(free_idx);
          occ_d[free_idx] = item_i.handle != '0;
          wr_en_c         = 1'b1;
          wr_addr_c       = free_idx;
        end else if (mark_ext < eff_cap) begin
          status_c                  = StatusOk;
          slot_c                    = mark_ext;
          occ_d[mark_q[SlotW-1:0]]  = item_i.handle != '0;
          mark_d                    = mark_q + MarkW'(1);
          wr_en_c                   = 1'b1;
          wr_addr_c                 = mark_q[SlotW-1:0];
        end
      end
      KindRemove: begin
        if (idx_ok && hit_occ) begin
          status_c                  = StatusOk;
          slot_c                    = idx_ext;
          occ_d[idx_ext[SlotW-1:0]] = 1'b0;
        end
      end
      KindRead: begin
        if (idx_ok && hit_occ) begin
          status_c = StatusOk;
          rd_c     = rdata_i;
        end
      end
      KindFlush: begin
        status_c = StatusOk;
        occ_d    = '0;
        mark_d   = '0;
      end
      default: begin
        status_c = StatusFail;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= '0;
      mark_q <= '0;
    end else if (fire_i) begin
      occ_q  <= occ_d;
      mark_q <= mark_d;
    end
  end

  assign res_o.status      = status_c;
  assign res_o.result_slot = slot_c[ResultSlotW-1:0];
  assign res_o.read_handle = rd_c;

  assign wr_o.en   = fire_i && wr_en_c;
  assign wr_o.addr = wr_addr_c;
  assign wr_o.data = item_i.handle;

endmodule

### rtl/first_free_slot_table_core.sv
// Top level of the first-free slot table: input register, handle RAM,
// allocator and result register. Depends on fst_pkg, fst_ram and fst_alloc.
//
// Use: operations (add, remove, read, flush) enter on the in_ channel as one
// word each; every word yields exactly one result word on the out_ channel,
// in order. The capacity register is written through cfg_we_i/cfg_wdata_i;
// the user is to write it only while the block is idle; the block does not enforce this.
// Path: an accepted word is held in the input register, and its result is
// captured in the result register and driven on out_data_o. The handle RAM is
// read at accept time, so the read data is waiting when the word sits in the
// input register; a same-cycle write from the word ahead is forwarded.
// Throughput: one word per cycle while out_ready_i is high. The first-free
// search is a single priority encoder over the occupancy bits, evaluated
// between the input register and the result register.
// Reset: all slots empty, mark zero, capacity 64; the RAM contents are not
// cleared, since a slot is read only while its occupancy bit is set.
// Stall: when out_ready_i is low the result is held; one more word may enter
// the input register, after which in_ready_o drops until the result leaves.
module first_free_slot_table_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  fst_pkg::in_t             in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output fst_pkg::out_t            out_data_o,
  input  logic                     cfg_we_i,
  input  logic [fst_pkg::CapW-1:0] cfg_wdata_i
);
  import fst_pkg::*;

  logic               stage_valid_q;
  in_t                stage_q;
  logic               out_valid_q;
  out_t               out_q;
  logic [CapW-1:0]    cap_q;
  logic               fwd_q;
  logic [HandleW-1:0] fwd_data_q;

  logic               accept, fire;
  logic [CmpW-1:0]    raddr_ext;
  logic [SlotW-1:0]   raddr;
  logic [HandleW-1:0] ram_rdata, rdata_eff;
  out_t               res;
  wr_t                wr;

  assign fire       = stage_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !stage_valid_q || fire;
  assign accept     = in_valid_i && in_ready_o;

  assign raddr_ext = CmpW'(in_data_i.slot_index);
  assign raddr     = raddr_ext[SlotW-1:0];
  assign rdata_eff = fwd_q ? fwd_data_q : ram_rdata;

  fst_ram #(
    .Width(HandleW),
    .Depth(MaxSlots)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr.en),
    .waddr_i(wr.addr),
    .wdata_i(wr.data),
    .re_i   (accept),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  fst_alloc u_alloc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (stage_q),
    .rdata_i(rdata_eff),
    .cap_i  (cap_q),
    .res_o  (res),
    .wr_o   (wr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
      cap_q         <= CapReset;
      fwd_q         <= 1'b0;
    end else begin
      if (accept) begin
        stage_valid_q <= 1'b1;
      end else if (fire) begin
        stage_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      // The RAM returns old data when the word ahead writes the same slot.
      if (accept) begin
        fwd_q <= wr.en && (wr.addr == raddr);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q    <= in_data_i;
      fwd_data_q <= wr.data;
    end
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/fst_checker.sv
// Port-level checks for first_free_slot_table_core, attached with a bind.
// Depends on fst_pkg.
module fst_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input fst_pkg::out_t out_data_o
);
  import fst_pkg::*;

  // A held result keeps its valid and its word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result word changed or dropped");

  // A failed operation reports neither a slot nor a handle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == StatusFail |->
      out_data_o.result_slot == '0 && out_data_o.read_handle == '0)
    else $error("failed operation carries a slot or handle");

  // Only a successful read returns a handle, and a read reports no slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.read_handle != '0 |->
      out_data_o.status == StatusOk && out_data_o.result_slot == '0)
    else $error("handle returned outside a successful read");

  // Back-pressure on the input only comes from a result waiting downstream.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a waiting result");

endmodule

bind first_free_slot_table_core fst_checker u_fst_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
